/* rtl/spe_pkg.sv */
// Package for the swing peak event detector.
// Shared sample width, register reset value and the tracking flag type.
// No dependencies.
package spe_pkg;

    localparam int SAMPLE_W = 8;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'h10;

    typedef struct packed {
        logic have_previous;
        logic rising;
    } spe_flags_t;

endpackage

/* rtl/swing_peak_event_detector_core.sv */
// Swing peak event detector: input register, tracking step, result register.
// Samples pass the input register and step; events are held in the result register.
// Throughput: one sample per cycle; input stalls only while a held event blocks the step.
// Reset: clears tracking state and valid flags; threshold returns to 0x10.
// Depends on spe_pkg and spe_step.
module swing_peak_event_detector_core #(
    parameter int POSITION_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spe_pkg::SAMPLE_W-1:0] swing_threshold,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [spe_pkg::SAMPLE_W-1:0] sample,
    input  logic                         block_start,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [POSITION_BITS-1:0]     event_number,
    output logic [spe_pkg::SAMPLE_W-1:0] swing_height,
    output logic [POSITION_BITS-1:0]     swing_width,
    output logic [POSITION_BITS-1:0]     peak_position
);

    logic [spe_pkg::SAMPLE_W-1:0] threshold_reg;

    logic                         s1_valid_reg;
    logic [spe_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                         s1_start_reg;

    spe_pkg::spe_flags_t          flags_reg;
    spe_pkg::spe_flags_t          flags_next;
    logic [spe_pkg::SAMPLE_W-1:0] last_sample_reg;
    logic [spe_pkg::SAMPLE_W-1:0] last_sample_next;
    logic [spe_pkg::SAMPLE_W-1:0] valley_value_reg;
    logic [spe_pkg::SAMPLE_W-1:0] valley_value_next;
    logic [POSITION_BITS-1:0]     valley_position_reg;
    logic [POSITION_BITS-1:0]     valley_position_next;
    logic [spe_pkg::SAMPLE_W-1:0] last_height_reg;
    logic [spe_pkg::SAMPLE_W-1:0] last_height_next;
    logic [POSITION_BITS-1:0]     sample_position_reg;
    logic [POSITION_BITS-1:0]     sample_position_next;
    logic [POSITION_BITS-1:0]     event_counter_reg;
    logic [POSITION_BITS-1:0]     event_counter_next;

    logic                         fire;
    logic [POSITION_BITS-1:0]     ev_number;
    logic [spe_pkg::SAMPLE_W-1:0] ev_height;
    logic [POSITION_BITS-1:0]     ev_width;
    logic [POSITION_BITS-1:0]     ev_position;

    logic                         out_valid_reg;
    logic [POSITION_BITS-1:0]     out_number_reg;
    logic [spe_pkg::SAMPLE_W-1:0] out_height_reg;
    logic [POSITION_BITS-1:0]     out_width_reg;
    logic [POSITION_BITS-1:0]     out_position_reg;

    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid     = out_valid_reg;
    assign event_number  = out_number_reg;
    assign swing_height  = out_height_reg;
    assign swing_width   = out_width_reg;
    assign peak_position = out_position_reg;

    spe_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .sample               (s1_sample_reg),
        .block_start          (s1_start_reg),
        .threshold            (threshold_reg),
        .flags                (flags_reg),
        .last_sample          (last_sample_reg),
        .valley_value         (valley_value_reg),
        .valley_position      (valley_position_reg),
        .last_height          (last_height_reg),
        .sample_position      (sample_position_reg),
        .event_counter        (event_counter_reg),
        .flags_next           (flags_next),
        .last_sample_next     (last_sample_next),
        .valley_value_next    (valley_value_next),
        .valley_position_next (valley_position_next),
        .last_height_next     (last_height_next),
        .sample_position_next (sample_position_next),
        .event_counter_next   (event_counter_next),
        .fire                 (fire),
        .ev_number            (ev_number),
        .ev_height            (ev_height),
        .ev_width             (ev_width),
        .ev_position          (ev_position)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= spe_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= swing_threshold;
        end
    end

    // hold the input beat until the step can advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_start_reg  <= block_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg           <= '0;
            last_sample_reg     <= '0;
            valley_value_reg    <= '0;
            valley_position_reg <= '0;
            last_height_reg     <= '0;
            sample_position_reg <= '0;
            event_counter_reg   <= '0;
        end
        else if (advance)
        begin
            flags_reg           <= flags_next;
            last_sample_reg     <= last_sample_next;
            valley_value_reg    <= valley_value_next;
            valley_position_reg <= valley_position_next;
            last_height_reg     <= last_height_next;
            sample_position_reg <= sample_position_next;
            event_counter_reg   <= event_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
        begin
            out_number_reg   <= ev_number;
            out_height_reg   <= ev_height;
            out_width_reg    <= ev_width;
            out_position_reg <= ev_position;
        end
    end

endmodule

/* rtl/spe_step.sv */
// Combinational single-sample step of the swing tracker.
// Computes the next tracking state and an optional swing event.
// Depends on spe_pkg.
module spe_step #(
    parameter int POSITION_BITS = 20
) (
    input  logic [spe_pkg::SAMPLE_W-1:0] sample,
    input  logic                         block_start,
    input  logic [spe_pkg::SAMPLE_W-1:0] threshold,
    input  spe_pkg::spe_flags_t          flags,
    input  logic [spe_pkg::SAMPLE_W-1:0] last_sample,
    input  logic [spe_pkg::SAMPLE_W-1:0] valley_value,
    input  logic [POSITION_BITS-1:0]     valley_position,
    input  logic [spe_pkg::SAMPLE_W-1:0] last_height,
    input  logic [POSITION_BITS-1:0]     sample_position,
    input  logic [POSITION_BITS-1:0]     event_counter,
    output spe_pkg::spe_flags_t          flags_next,
    output logic [spe_pkg::SAMPLE_W-1:0] last_sample_next,
    output logic [spe_pkg::SAMPLE_W-1:0] valley_value_next,
    output logic [POSITION_BITS-1:0]     valley_position_next,
    output logic [spe_pkg::SAMPLE_W-1:0] last_height_next,
    output logic [POSITION_BITS-1:0]     sample_position_next,
    output logic [POSITION_BITS-1:0]     event_counter_next,
    output logic                         fire,
    output logic [POSITION_BITS-1:0]     ev_number,
    output logic [spe_pkg::SAMPLE_W-1:0] ev_height,
    output logic [POSITION_BITS-1:0]     ev_width,
    output logic [POSITION_BITS-1:0]     ev_position
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    spe_pkg::spe_flags_t          cur_flags;
    logic [spe_pkg::SAMPLE_W-1:0] cur_last;
    logic [spe_pkg::SAMPLE_W-1:0] cur_valley;
    logic [POSITION_BITS-1:0]     cur_valley_pos;
    logic [spe_pkg::SAMPLE_W-1:0] cur_height;
    logic [POSITION_BITS-1:0]     cur_pos;
    logic [POSITION_BITS-1:0]     cur_count;
    logic [spe_pkg::SAMPLE_W-1:0] height;

    always_comb
    begin
        if (block_start)
        begin
            cur_flags      = '0;
            cur_last       = '0;
            cur_valley     = '0;
            cur_valley_pos = '0;
            cur_height     = '0;
            cur_pos        = '0;
            cur_count      = '0;
        end
        else
        begin
            cur_flags      = flags;
            cur_last       = last_sample;
            cur_valley     = valley_value;
            cur_valley_pos = valley_position;
            cur_height     = last_height;
            cur_pos        = sample_position;
            cur_count      = event_counter;
        end
    end

    assign height      = cur_last - cur_valley;
    assign ev_number   = cur_count;
    assign ev_height   = height;
    assign ev_width    = cur_pos - cur_valley_pos;
    assign ev_position = cur_pos;

    always_comb
    begin
        flags_next           = cur_flags;
        last_sample_next     = sample;
        valley_value_next    = cur_valley;
        valley_position_next = cur_valley_pos;
        last_height_next     = cur_height;
        sample_position_next = cur_pos;
        event_counter_next   = cur_count;
        fire                 = 1'b0;
        if (!cur_flags.have_previous)
        begin
            flags_next.have_previous = 1'b1;
        end
        else
        begin
            sample_position_next = (cur_pos == POS_MAX) ? POS_MAX : cur_pos + 1'b1;
            if (sample > cur_last)
            begin
                if (!cur_flags.rising)
                begin
                    valley_value_next    = cur_last;
                    valley_position_next = cur_pos;
                    flags_next.rising    = 1'b1;
                end
            end
            else if (sample < cur_last)
            begin
                if (cur_flags.rising)
                begin
                    if (height > cur_height && height > threshold)
                    begin
                        fire               = 1'b1;
                        event_counter_next = (cur_count == POS_MAX) ? POS_MAX
                                                                    : cur_count + 1'b1;
                    end
                    last_height_next  = height;
                    flags_next.rising = 1'b0;
                end
            end
        end
    end

endmodule

/* dv/swing_peak_event_detector_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for swing_peak_event_detector_core: directed, threshold,
// back-pressure and random-walk sample streams, checked against a local swing tracker.
// Depends on spe_pkg and the detector RTL.
module swing_peak_event_detector_core_tb;

    localparam int POS_BITS    = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 13;

    typedef logic [spe_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t POS_TOP = '1;

    typedef struct {
        pos_t    number;
        sample_t height;
        pos_t    span;
        pos_t    peak;
    } swing_event_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    sample_t swing_threshold = '0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t sample = '0;
    logic    block_start = 1'b0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    pos_t    event_number;
    sample_t swing_height;
    pos_t    swing_width;
    pos_t    peak_position;

    swing_peak_event_detector_core #(
        .POSITION_BITS(POS_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .swing_threshold(swing_threshold),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .block_start    (block_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_number   (event_number),
        .swing_height   (swing_height),
        .swing_width    (swing_width),
        .peak_position  (peak_position)
    );

    // tracker state
    sample_t thr_q;
    sample_t last_q;
    sample_t valley_val_q;
    sample_t last_height_q;
    bit      have_prev_q;
    bit      rising_q;
    pos_t    valley_pos_q;
    pos_t    pos_q;
    pos_t    events_q;

    swing_event_t expected_events[$];
    swing_event_t head_event;

    bit gaps_on = 1'b1;
    int rx_wait = 0;
    int rx_hold = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int events_seen = 0;
    int blocks_started = 0;
    int threshold_writes = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, expected_events.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver: per-beat random stall plus an optional long hold
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold--;
        end
        else if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch("unexpected event, number", event_number, 0);
            else
            begin
                head_event = expected_events.pop_front();
                if (event_number !== head_event.number)
                    report_mismatch("event_number", event_number, head_event.number);
                if (swing_height !== head_event.height)
                    report_mismatch("swing_height", swing_height, head_event.height);
                if (swing_width !== head_event.span)
                    report_mismatch("swing_width", swing_width, head_event.span);
                if (peak_position !== head_event.peak)
                    report_mismatch("peak_position", peak_position, head_event.peak);
            end
            events_seen++;
            rx_wait = gaps_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
        end
    end

    task automatic clear_tracking();
        last_q        = '0;
        have_prev_q   = 1'b0;
        rising_q      = 1'b0;
        valley_val_q  = '0;
        valley_pos_q  = '0;
        last_height_q = '0;
        pos_q         = '0;
        events_q      = '0;
    endtask

    task automatic track_swing(input sample_t s, input logic bs);
        swing_event_t ev;
        pos_t         prev;
        sample_t      h;
        if (bs)
            clear_tracking();
        if (!have_prev_q)
        begin
            last_q      = s;
            have_prev_q = 1'b1;
            return;
        end
        prev = pos_q;
        if (pos_q != POS_TOP)
            pos_q++;
        if (s > last_q)
        begin
            if (!rising_q)
            begin
                valley_val_q = last_q;
                valley_pos_q = prev;
                rising_q     = 1'b1;
            end
        end
        else if (s < last_q && rising_q)
        begin
            h = last_q - valley_val_q;
            if (h > last_height_q && h > thr_q)
            begin
                ev.number = events_q;
                ev.height = h;
                ev.span   = prev - valley_pos_q;
                ev.peak   = prev;
                expected_events.push_back(ev);
                if (events_q != POS_TOP)
                    events_q++;
            end
            last_height_q = h;
            rising_q      = 1'b0;
        end
        last_q = s;
    endtask

    task automatic send_sample(input sample_t s, input logic bs);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        block_start <= bs;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        track_swing(s, bs);
        samples_sent++;
        if (bs)
            blocks_started++;
    endtask

    // hold input until every event is out, then let the pipeline settle
    task automatic drain_events();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input sample_t value);
        cfg_valid       <= 1'b1;
        swing_threshold <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        thr_q = value;
        threshold_writes++;
    endtask

    task automatic test_reset_threshold();
        send_sample(8'd100, 1'b0);
        send_sample(8'd116, 1'b0);
        send_sample(8'd100, 1'b0);
        send_sample(8'd117, 1'b0);
        send_sample(8'd0, 1'b0);
        drain_events();
    endtask

    task automatic test_directed_extremes();
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd200, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd254, 1'b0);
        send_sample(8'd10, 1'b0);
        send_sample(8'd10, 1'b0);
        send_sample(8'd250, 1'b0);
        send_sample(8'd128, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd40, 1'b0);
        send_sample(8'd200, 1'b1);
        send_sample(8'd1, 1'b0);
        send_sample(8'd170, 1'b0);
        send_sample(8'd85, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        drain_events();
    endtask

    task automatic test_threshold_settings();
        sample_t levels[3];
        levels[0] = 8'd0;
        levels[1] = 8'd255;
        levels[2] = 8'd100;
        foreach (levels[k])
        begin
            write_threshold(levels[k]);
            send_sample(8'd50, 1'b1);
            send_sample(8'd51, 1'b0);
            send_sample(8'd50, 1'b0);
            send_sample(8'd0, 1'b0);
            send_sample(8'd255, 1'b0);
            send_sample(8'd0, 1'b0);
            send_sample(8'd100, 1'b0);
            send_sample(8'd0, 1'b0);
            send_sample(8'd101, 1'b0);
            send_sample(8'd0, 1'b0);
            drain_events();
        end
    endtask

    task automatic test_back_pressure();
        write_threshold(8'd5);
        gaps_on = 1'b0;
        rx_hold = 300;
        send_sample(8'd0, 1'b1);
        repeat (15)
        begin
            send_sample(8'd250, 1'b0);
            send_sample(8'd3, 1'b0);
            send_sample(8'd90, 1'b0);
            send_sample(8'd3, 1'b0);
        end
        drain_events();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_walk(input int phases, input int per_phase);
        sample_t cur;
        sample_t s;
        bit      up;
        bit      bs;
        int      run;
        int      r;
        int      step;
        cur = sample_t'($urandom);
        up  = ($urandom_range(0, 1) == 1);
        run = $urandom_range(1, 6);
        for (int p = 0; p < phases; p++)
        begin
            write_threshold(($urandom_range(0, 3) == 0) ? sample_t'($urandom)
                                                        : sample_t'($urandom_range(0, 40)));
            gaps_on = (p % 3) != 1;
            for (int i = 0; i < per_phase; i++)
            begin
                r  = $urandom_range(0, 99);
                bs = (r < 3);
                if (r < 12)
                    s = sample_t'($urandom);
                else if (r < 20)
                    s = cur;
                else
                begin
                    step = $urandom_range(1, 80);
                    if (up)
                        s = (cur + step > 255) ? 8'd255 : sample_t'(cur + step);
                    else
                        s = (cur < step) ? 8'd0 : sample_t'(cur - step);
                    run--;
                    if (run == 0)
                    begin
                        up  = !up;
                        run = $urandom_range(1, 5);
                    end
                end
                send_sample(s, bs);
                cur = s;
            end
            drain_events();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        thr_q = spe_pkg::THRESHOLD_RESET;
        clear_tracking();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_threshold();
        test_directed_extremes();
        test_threshold_settings();
        test_back_pressure();
        test_random_walk(5, 85);

        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d samples in %0d blocks, %0d events, %0d threshold settings",
                 samples_sent, blocks_started, events_seen, threshold_writes);
        $display("including extreme swings, block restarts and a long output hold");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* swing_peak_event_detector_core.f */
rtl/spe_pkg.sv
rtl/spe_step.sv
rtl/swing_peak_event_detector_core.sv
dv/swing_peak_event_detector_core_tb.sv
